FILE: hw/rtl/xmc_pkg.sv
// ----------------------------------------------------------------------------
// xmc_pkg
// Shared types and constants for the subarray XOR match counter.
// ----------------------------------------------------------------------------
package xmc_pkg;

    localparam int TARGET_W   = 8;
    localparam int VALUE_W    = 8;
    localparam int TOTAL_W    = 24;
    localparam int EPOCH_BITS = 8;
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);
    localparam int OCC_W      = $clog2(RES_DEPTH + 1);
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // register index, taken from paddr[2]
    localparam logic REG_TARGET_XOR = 1'b0;

    typedef struct packed {
        logic [TOTAL_W-1:0] match_count;
        logic               too_long;
    } res_t;

endpackage

FILE: hw/rtl/xmc_hist_ram.sv
// ----------------------------------------------------------------------------
// xmc_hist_ram
// Histogram store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module xmc_hist_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 21
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the contents before a same-edge write
    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: hw/rtl/xmc_res_fifo.sv
// ----------------------------------------------------------------------------
// xmc_res_fifo
// Small result queue in front of the master stream port.
// ----------------------------------------------------------------------------
module xmc_res_fifo
    import xmc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  res_t             push_item,
    output logic             out_valid,
    input  logic             out_ready,
    output res_t             out_item,
    output logic [OCC_W-1:0] occupancy
);

    res_t                 slot [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg;
    logic [RES_PTR_W-1:0] rd_ptr_reg;
    logic [OCC_W-1:0]     occ_reg;
    logic                 pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (occ_reg != '0);
    assign out_item  = slot[rd_ptr_reg];
    assign occupancy = occ_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   occ_reg <= occ_reg + 1'b1;
                2'b01:   occ_reg <= occ_reg - 1'b1;
                default: occ_reg <= occ_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/subarray_xor_match_counter_unit.sv
// The last beat's result passes the lookup stage register into the result queue.
// Throughput: one input beat per cycle; s_tready drops while the 4-deep result queue,
// counting the result still in the lookup stage, is full.
// Every 256 arrays the histogram tag wraps and a clearing pass over all bins
// (held back while the closing beat still writes its bin) runs with s_tready low.
// Reset (aresetn low, synchronous) clears control state and starts a clearing pass.
// ----------------------------------------------------------------------------
// subarray_xor_match_counter_unit
// Counts subarrays whose XOR equals target_xor using a prefix XOR histogram
// held in a tagged RAM with read-modify-write forwarding.
// ----------------------------------------------------------------------------
module subarray_xor_match_counter_unit
    import xmc_pkg::*;
#(
    parameter int VALUE_BITS = 8,
    parameter int MAX_LEN    = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VALUE_W-1:0]    s_tdata,   // [7:0] value
    input  logic                  s_tlast,   // last
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TOTAL_W-1:0]    m_tdata,   // [23:0] match_count
    output logic [0:0]            m_tuser,   // [0] too_long
    // APB
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int ENT_W = EPOCH_BITS + CNT_W;
    localparam logic [63:0] WIDE_TOTAL = 64'(MAX_LEN) * (64'(MAX_LEN) + 64'd1) / 64'd2;
    localparam logic [TOTAL_W-1:0] SAT_TOTAL =
        (WIDE_TOTAL > 64'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(WIDE_TOTAL);

    // configuration
    logic [TARGET_W-1:0] target_reg;

    // array state
    logic [VALUE_BITS-1:0] prefix_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  ovf_reg;
    logic [EPOCH_BITS-1:0] epoch_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic                  clearing_reg;
    logic [VALUE_BITS-1:0] clr_addr_reg;

    // lookup stage
    logic                  s1_valid_reg;
    logic                  s1_counted_reg;
    logic                  s1_last_reg;
    logic                  s1_ovf_reg;
    logic [VALUE_BITS-1:0] s1_p_reg;
    logic [VALUE_BITS-1:0] s1_w_reg;
    logic [EPOCH_BITS-1:0] s1_epoch_reg;

    // last RAM write, for forwarding into the lookup stage
    logic                  wl_valid_reg;
    logic [VALUE_BITS-1:0] wl_addr_reg;
    logic [ENT_W-1:0]      wl_data_reg;

    logic                  accept;
    logic [VALUE_BITS-1:0] val;
    logic [VALUE_BITS-1:0] tgt;
    logic [VALUE_BITS-1:0] pfx;
    logic [VALUE_BITS-1:0] want;
    logic                  counted;

    logic [ENT_W-1:0]      rd_w;
    logic [ENT_W-1:0]      rd_p;
    logic [ENT_W-1:0]      ent_w;
    logic [ENT_W-1:0]      ent_p;
    logic [CNT_W-1:0]      cnt_w;
    logic [CNT_W-1:0]      cnt_p;
    logic [CNT_W:0]        hist_w;
    logic [TOTAL_W:0]      sum;
    logic [TOTAL_W-1:0]    total_new;

    logic                  s1_wr;
    logic                  wr_en;
    logic [VALUE_BITS-1:0] wr_addr;
    logic [ENT_W-1:0]      wr_data;

    logic                  res_push;
    res_t                  res_item;
    res_t                  out_item;
    logic [OCC_W-1:0]      occ;
    logic                  pending;

    // ------------------------------------------------------------------------
    // APB
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TARGET_XOR) ? APB_DW'(target_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TARGET_XOR) begin
            target_reg <= pwdata[TARGET_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Accept stage: update prefix, issue both histogram reads
    // ------------------------------------------------------------------------
    assign pending  = s1_valid_reg && s1_last_reg;
    assign s_tready = !clearing_reg &&
                      (({1'b0, occ} + (OCC_W + 1)'(pending)) <= (OCC_W + 1)'(RES_DEPTH - 1));
    assign accept   = s_tvalid && s_tready;

    assign val     = VALUE_BITS'(s_tdata);
    assign tgt     = VALUE_BITS'(target_reg);
    assign pfx     = prefix_reg ^ val;
    assign want    = pfx ^ tgt;
    assign counted = (cnt_reg < CNT_W'(MAX_LEN));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg   <= '0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            epoch_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                if (s_tlast) begin
                    prefix_reg <= '0;
                    cnt_reg    <= '0;
                    ovf_reg    <= 1'b0;
                    epoch_reg  <= epoch_reg + 1'b1;
                end else if (counted) begin
                    prefix_reg <= pfx;
                    cnt_reg    <= cnt_reg + 1'b1;
                end else begin
                    ovf_reg    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_counted_reg <= counted;
            s1_last_reg    <= s_tlast;
            s1_ovf_reg     <= ovf_reg || !counted;
            s1_p_reg       <= pfx;
            s1_w_reg       <= want;
            s1_epoch_reg   <= epoch_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Histogram RAM
    // ------------------------------------------------------------------------
    xmc_hist_ram #(
        .ADDR_W (VALUE_BITS),
        .DATA_W (ENT_W)
    ) u_hist (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (want),
        .rd_addr_b (pfx),
        .rd_data_a (rd_w),
        .rd_data_b (rd_p)
    );

    // ------------------------------------------------------------------------
    // Lookup stage: forward, check tag, accumulate, write back
    // ------------------------------------------------------------------------
    assign ent_w = (wl_valid_reg && wl_addr_reg == s1_w_reg) ? wl_data_reg : rd_w;
    assign ent_p = (wl_valid_reg && wl_addr_reg == s1_p_reg) ? wl_data_reg : rd_p;

    // entries from an older array read as empty
    assign cnt_w = (ent_w[ENT_W-1:CNT_W] == s1_epoch_reg) ? ent_w[CNT_W-1:0] : '0;
    assign cnt_p = (ent_p[ENT_W-1:CNT_W] == s1_epoch_reg) ? ent_p[CNT_W-1:0] : '0;

    // bin zero also holds the empty prefix, which is not stored
    assign hist_w    = {1'b0, cnt_w} + (CNT_W + 1)'(s1_w_reg == '0);
    assign sum       = {1'b0, total_reg} + (TOTAL_W + 1)'(hist_w);
    assign total_new = (sum > {1'b0, SAT_TOTAL}) ? SAT_TOTAL : sum[TOTAL_W-1:0];

    assign s1_wr   = s1_valid_reg && s1_counted_reg;
    assign wr_en   = s1_wr || clearing_reg;
    assign wr_addr = s1_wr ? s1_p_reg : clr_addr_reg;
    assign wr_data = s1_wr ? {s1_epoch_reg, cnt_p + 1'b1} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= '0;
            wl_valid_reg <= 1'b0;
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            wl_valid_reg <= wr_en;
            if (s1_valid_reg) begin
                if (s1_last_reg) begin
                    total_reg <= '0;
                end else if (s1_counted_reg) begin
                    total_reg <= total_new;
                end
            end
            // tag wraps: sweep the RAM before the tag is reused
            if (accept && s_tlast && epoch_reg == '1) begin
                clearing_reg <= 1'b1;
                clr_addr_reg <= '0;
            end else if (clearing_reg && !s1_wr) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1) begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        wl_addr_reg <= wr_addr;
        wl_data_reg <= wr_data;
    end

    // ------------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------------
    assign res_push             = s1_valid_reg && s1_last_reg;
    assign res_item.match_count = s1_ovf_reg ? SAT_TOTAL : total_new;
    assign res_item.too_long    = s1_ovf_reg;

    xmc_res_fifo u_res (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_item (res_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item),
        .occupancy (occ)
    );

    assign m_tdata    = out_item.match_count;
    assign m_tuser[0] = out_item.too_long;

endmodule

FILE: hw/rtl/xmc_checker.sv
// ----------------------------------------------------------------------------
// xmc_checker
// Port-level checks for the subarray XOR match counter.
// ----------------------------------------------------------------------------
module xmc_checker
    import xmc_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               s_tlast,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TOTAL_W-1:0] m_tdata,
    input logic [0:0]         m_tuser
);

    localparam logic [63:0] WIDE_TOTAL = 64'(MAX_LEN) * (64'(MAX_LEN) + 64'd1) / 64'd2;
    localparam logic [TOTAL_W-1:0] SAT_TOTAL =
        (WIDE_TOTAL > 64'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(WIDE_TOTAL);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // the histogram sweep after reset keeps the input closed
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input open right after reset");

    // an overlong array reports the saturated count
    a_too_long: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == SAT_TOTAL)
        else $error("too_long without saturated count");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= SAT_TOTAL)
        else $error("match_count above saturation value");

    // a queue that goes non-empty was fed by an accepted last beat, through the lookup stage register
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a last beat");

endmodule

bind subarray_xor_match_counter_unit xmc_checker #(.MAX_LEN(MAX_LEN)) u_xmc_checker (.*);
